// ===== rtl/sba_pkg.sv =====
// Shared types, constants and a helper function for the sector bitmap allocator.
// No dependencies; sba_word, sba_ctrl and the top level import this package.
package sba_pkg;

  localparam int SECTORS = 720;
  localparam int SEC_W   = 10;
  localparam int CNT_W   = 11;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int WORDS   = (SECTORS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [SEC_W-1:0] sector_in;
  } req_t;

  typedef struct packed {
    logic [SEC_W-1:0] sector_out;
    status_t          status;
    logic             was_free;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

  // Bits of a map word that allocate may hand out: in range, never sector 0.
  function automatic logic [WORD_W-1:0] alloc_mask(input logic [WADDR_W-1:0] widx);
    logic [WORD_W-1:0] m;
    int unsigned       base;
    base = int'(widx) * WORD_W;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((base + b) < SECTORS) && ((base + b) != 0);
    end
    return m;
  endfunction

endpackage

// ===== rtl/sba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sba_word.sv =====
// Word-level bitmap logic: first-free search in one map word and the modified word.
// Depends on sba_pkg.
module sba_word import sba_pkg::*; (
  input  logic [WORD_W-1:0]  word,
  input  logic [WADDR_W-1:0] widx,
  input  logic [BIT_W-1:0]   bsel,
  input  op_t                op,
  output logic               hit,
  output logic [BIT_W-1:0]   hit_pos,
  output logic               bit_val,
  output logic [WORD_W-1:0]  word_next
);

  logic [WORD_W-1:0] cand;
  logic [WORD_W-1:0] lowest;
  logic [WORD_W-1:0] onehot;

  always_comb begin
    cand    = word & alloc_mask(widx);
    // isolate the lowest set bit
    lowest  = cand & (~cand + WORD_W'(1));
    hit     = |cand;
    hit_pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (lowest[b]) begin
        hit_pos = hit_pos | BIT_W'(b);
      end
    end
    onehot  = WORD_W'(1) << bsel;
    bit_val = word[bsel];
    case (op)
      OP_ALLOC:   word_next = word & ~lowest;
      OP_RELEASE: word_next = word | onehot;
      OP_RESERVE: word_next = word & ~onehot;
      default:    word_next = word;
    endcase
  end

endmodule

// ===== rtl/sba_ctrl.sv =====
// Request sequencer: reads map words from the bitmap RAM, modifies and writes back,
// keeps the free count. Depends on sba_pkg, sba_ram and sba_word.
module sba_ctrl import sba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  state_t              state, state_next;
  op_t                 op_q;
  logic [SEC_W-1:0]    sec_q;
  logic [WADDR_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]    free_total, free_next;
  logic [WORDS-1:0]    row_valid;
  rsp_t                res_q, res_next;

  logic                accept;
  logic                in_range;
  logic [WADDR_W-1:0]  req_widx;
  logic [WADDR_W-1:0]  raddr;
  logic                we;
  logic [WORD_W-1:0]   rdata;
  logic [WORD_W-1:0]   word_in;
  logic                hit;
  logic [BIT_W-1:0]    hit_pos;
  logic                bit_val;
  logic [WORD_W-1:0]   word_next;
  logic                last_word;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign in_range  = {1'b0, req.sector_in} < CNT_W'(SECTORS);
  assign req_widx  = WADDR_W'(req.sector_in[SEC_W-1:BIT_W]);
  assign last_word = (idx == WADDR_W'(WORDS - 1));
  // a word never written reads as all used
  assign word_in   = row_valid[idx] ? rdata : '0;

  sba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (word_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  sba_word u_word (
    .word      (word_in),
    .widx      (idx),
    .bsel      (sec_q[BIT_W-1:0]),
    .op        (op_q),
    .hit       (hit),
    .hit_pos   (hit_pos),
    .bit_val   (bit_val),
    .word_next (word_next)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_ALLOC) begin
            state_next = S_SCAN;
          end else if (!in_range) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: state_next = S_RESULT;
      S_SCAN: begin
        if (hit || last_word) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    raddr     = idx;
    we        = 1'b0;
    idx_next  = idx;
    free_next = free_total;
    res_next  = res_q;
    case (state)
      S_IDLE: begin
        raddr = (req.op == OP_ALLOC) ? '0 : req_widx;
        if (accept) begin
          idx_next = (req.op == OP_ALLOC) ? '0 : req_widx;
          res_next = '{sector_out: req.sector_in, status: STAT_RANGE,
                       was_free: 1'b0, free_count: free_total};
        end
      end
      S_LOOKUP: begin
        if (op_q == OP_RELEASE && !bit_val) begin
          we        = 1'b1;
          free_next = free_total + CNT_W'(1);
        end else if (op_q == OP_RESERVE && bit_val) begin
          we        = 1'b1;
          free_next = free_total - CNT_W'(1);
        end
        res_next = '{sector_out: sec_q, status: STAT_OK,
                     was_free: bit_val, free_count: free_next};
      end
      S_SCAN: begin
        // prefetch the following word while this one is checked
        raddr = idx + 1'b1;
        if (hit) begin
          we        = 1'b1;
          free_next = free_total - CNT_W'(1);
          res_next  = '{sector_out: SEC_W'({idx, hit_pos}), status: STAT_OK,
                        was_free: 1'b1, free_count: free_next};
        end else if (last_word) begin
          res_next = '{sector_out: '0, status: STAT_FULL,
                       was_free: 1'b0, free_count: free_total};
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_total <= '0;
      row_valid  <= '0;
    end else begin
      state      <= state_next;
      free_total <= free_next;
      if (we) begin
        row_valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.op;
      sec_q <= req.sector_in;
    end
    idx   <= idx_next;
    res_q <= res_next;
  end

  assign res_valid = (state == S_RESULT);
  assign res       = res_q;

endmodule

// ===== rtl/sector_bitmap_allocator_top.sv =====
// Sector bitmap allocator, top level. Depends on sba_pkg and sba_ctrl.
// Sequence: release/reserve/query go through the lookup and result states to the output
// register, out-of-range goes straight to result, allocate scans words (at most WORDS = 12).
// Flow: one request at a time; the next is accepted once the result has loaded into the
// output register, so a sink that does not keep up holds off new requests.
// Reset: synchronous; the map reads as all used through per-word valid flags.
module sector_bitmap_allocator_top import sba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic res_valid;
  logic res_ready;
  rsp_t res;

  // Sequencer: owns the bitmap RAM and the free count.
  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a new beat when empty or when the current one drains.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold payload until the next beat is loaded.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("sequencer took a request while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, rsp.free_count} <= (CNT_W + 1)'(SECTORS)))
    else $error("free count exceeds sector count");

  // Sector 0 may still be free when allocate finds no space.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_FULL) |-> (rsp.sector_out == '0 && !rsp.was_free
      && rsp.free_count <= CNT_W'(1)))
    else $error("no-space result inconsistent");

  a_range_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_RANGE) |->
      (!rsp.was_free && ({1'b0, rsp.sector_out} >= CNT_W'(SECTORS))))
    else $error("range result inconsistent");
`endif

endmodule
